/* rtl/mma_pkg.sv */
// Shared types for the MIDI message assembler.
// Holds the parser phase and readout state encodings; no dependencies.
`default_nettype none

package mma_pkg;

  // Parser phase: which byte of a message is expected next.
  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_FIRST  = 3'd1,
    PH_SECOND = 3'd2,
    PH_SINGLE = 3'd3,
    PH_SYSEX  = 3'd4
  } phase_t;

  // Readout sequencer state.
  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_READ = 2'd1,
    EM_LOAD = 2'd2
  } emit_state_t;

  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_MTC       = 8'hF1;
  localparam logic [7:0] ST_SONG_POS  = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_EOX       = 8'hF7;
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_POLY_AT   = 4'hA;
  localparam logic [3:0] HI_CTRL      = 4'hB;
  localparam logic [3:0] HI_PROG      = 4'hC;
  localparam logic [3:0] HI_CHAN_AT   = 4'hD;
  localparam logic [3:0] HI_PITCH     = 4'hE;
  localparam logic [3:0] HI_SYSTEM    = 4'hF;

endpackage

`default_nettype wire

/* rtl/mma_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the message store of the MIDI message assembler.
`default_nettype none

module mma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/midi_message_assembler.sv */
// MIDI message assembler top level: parser, message store and readout.
// Depends on mma_pkg and mma_ram.
//
// Usage: the input channel (in_valid, in_stall, in_byte) takes one MIDI byte
// per transfer. Status bytes start a message, data bytes fill it, running
// status is kept for channel and one/two-data-byte system messages, and a
// sysex message is collected until F7. Every completed message leaves on the
// output channel (out_valid, out_stall, out_msg_byte, out_last,
// out_truncated) as a run of bytes, status first, out_last on the final one.
// Each byte of a message is written into the message store as it is
// accepted, but for sysex bytes beyond its capacity. A byte that completes
// no message causes no input stall. A completing byte starts a readout from
// the store: each output byte is read (EM_READ), then moved into the output
// register (EM_LOAD) once that is free, and the input stays stalled until
// the last byte is moved. The output register holds its byte while out_stall
// is high; the last byte of a run may wait there while the next input byte
// is already accepted. Reset returns the parser to waiting for a status
// byte and empties the output register; the store needs no clearing.
`default_nettype none

module midi_message_assembler
  import mma_pkg::*;
#(
  parameter int MAX_MESSAGE_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_msg_byte,
  output logic            out_last,
  output logic            out_truncated
);

  localparam int AW = $clog2(MAX_MESSAGE_BYTES);
  localparam int LW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [LW-1:0] MAX_LEN  = LW'(MAX_MESSAGE_BYTES);
  localparam logic [LW-1:0] MAX_DATA = LW'(MAX_MESSAGE_BYTES - 1);

  phase_t            phase_r,     phase_nxt;
  logic [LW-1:0]     msg_len_r,   msg_len_nxt;
  logic              ovf_r,       ovf_nxt;
  emit_state_t       emit_st_r,   emit_st_nxt;
  logic [LW-1:0]     emit_len_r,  emit_len_nxt;
  logic [AW-1:0]     rd_idx_r,    rd_idx_nxt;
  logic              emit_trunc_r, emit_trunc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r,  out_byte_nxt;
  logic              out_last_r,  out_last_nxt;
  logic              out_trunc_r, out_trunc_nxt;

  logic              accept;
  logic              is_status;
  phase_t            st_phase;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [7:0]        rd_data;
  logic              slot_free;
  logic              rd_is_last;

  // Message store.
  mma_ram #(
    .WIDTH (8),
    .DEPTH (MAX_MESSAGE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  // Status byte decode and the phase it leads to.
  always_comb begin
    is_status = 1'b0;
    st_phase  = PH_WAIT;
    case (in_byte[7:4])
      HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CTRL, HI_PITCH: begin
        is_status = 1'b1;
        st_phase  = PH_FIRST;
      end
      HI_PROG, HI_CHAN_AT: begin
        is_status = 1'b1;
        st_phase  = PH_SINGLE;
      end
      HI_SYSTEM: begin
        if (in_byte == ST_SYSEX) begin
          is_status = 1'b1;
          st_phase  = PH_SYSEX;
        end else if (in_byte == ST_MTC || in_byte == ST_SONG_SEL) begin
          is_status = 1'b1;
          st_phase  = PH_SINGLE;
        end else if (in_byte == ST_SONG_POS) begin
          is_status = 1'b1;
          st_phase  = PH_FIRST;
        end
      end
      default: begin
        is_status = 1'b0;
      end
    endcase
  end

  assign in_stall   = (emit_st_r != EM_IDLE);
  assign accept     = in_valid && !in_stall;
  assign slot_free  = !out_valid_r || !out_stall;
  assign rd_is_last = ((LW'(rd_idx_r) + LW'(1)) == emit_len_r);
  assign rd_en      = (emit_st_r == EM_READ);

  // Parser, store writes and readout sequencer.
  always_comb begin
    phase_nxt      = phase_r;
    msg_len_nxt    = msg_len_r;
    ovf_nxt        = ovf_r;
    emit_st_nxt    = emit_st_r;
    emit_len_nxt   = emit_len_r;
    rd_idx_nxt     = rd_idx_r;
    emit_trunc_nxt = emit_trunc_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_trunc_nxt  = out_trunc_r;
    wr_en          = 1'b0;
    wr_addr        = '0;

    // Output register drains on a transfer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (emit_st_r)
      EM_IDLE: begin
        if (accept) begin
          if (is_status) begin
            wr_en       = 1'b1;
            wr_addr     = '0;
            msg_len_nxt = LW'(1);
            ovf_nxt     = 1'b0;
            phase_nxt   = st_phase;
          end else begin
            case (phase_r)
              PH_FIRST: begin
                wr_en     = 1'b1;
                wr_addr   = AW'(1);
                phase_nxt = PH_SECOND;
              end
              PH_SECOND: begin
                wr_en          = 1'b1;
                wr_addr        = AW'(2);
                phase_nxt      = PH_FIRST;
                emit_len_nxt   = LW'(3);
                emit_trunc_nxt = 1'b0;
                rd_idx_nxt     = '0;
                emit_st_nxt    = EM_READ;
              end
              PH_SINGLE: begin
                wr_en          = 1'b1;
                wr_addr        = AW'(1);
                emit_len_nxt   = LW'(2);
                emit_trunc_nxt = 1'b0;
                rd_idx_nxt     = '0;
                emit_st_nxt    = EM_READ;
              end
              PH_SYSEX: begin
                if (in_byte == ST_EOX) begin
                  if (msg_len_r < MAX_LEN) begin
                    wr_en        = 1'b1;
                    wr_addr      = msg_len_r[AW-1:0];
                    msg_len_nxt  = msg_len_r + LW'(1);
                    emit_len_nxt = msg_len_r + LW'(1);
                  end else begin
                    emit_len_nxt = msg_len_r;
                  end
                  emit_trunc_nxt = ovf_r;
                  ovf_nxt        = 1'b0;
                  rd_idx_nxt     = '0;
                  phase_nxt      = PH_WAIT;
                  emit_st_nxt    = EM_READ;
                end else if (msg_len_r < MAX_DATA) begin
                  wr_en       = 1'b1;
                  wr_addr     = msg_len_r[AW-1:0];
                  msg_len_nxt = msg_len_r + LW'(1);
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
              default: begin
                phase_nxt = phase_r;
              end
            endcase
          end
        end
      end
      EM_READ: begin
        emit_st_nxt = EM_LOAD;
      end
      EM_LOAD: begin
        // Move the read byte into the output register once it is free.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data;
          out_last_nxt  = rd_is_last;
          out_trunc_nxt = emit_trunc_r;
          if (rd_is_last) begin
            emit_st_nxt = EM_IDLE;
          end else begin
            rd_idx_nxt  = rd_idx_r + AW'(1);
            emit_st_nxt = EM_READ;
          end
        end
      end
      default: begin
        emit_st_nxt = EM_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      msg_len_r   <= '0;
      ovf_r       <= 1'b0;
      emit_st_r   <= EM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      msg_len_r   <= msg_len_nxt;
      ovf_r       <= ovf_nxt;
      emit_st_r   <= emit_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    emit_len_r   <= emit_len_nxt;
    rd_idx_r     <= rd_idx_nxt;
    emit_trunc_r <= emit_trunc_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_trunc_r  <= out_trunc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_msg_byte  = out_byte_r;
  assign out_last      = out_last_r;
  assign out_truncated = out_trunc_r;

endmodule

`default_nettype wire

/* tb/midi_message_assembler_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the MIDI message assembler: watches both channels, predicts
// the message runs from the accepted bytes and compares every result transfer.
// Depends on mma_pkg for the parser phase type and the status byte constants.

module midi_message_assembler_checker
  import mma_pkg::*;
#(
  parameter int MAX_MESSAGE_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_msg_byte,
  input  logic       out_last,
  input  logic       out_truncated,
  output int         error_count,
  output int         awaited_bytes,
  output int         parsed_bytes
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last;
    logic       truncated;
  } msg_beat_t;

  // Expected message bytes, oldest first.
  msg_beat_t  run_queue [$];

  // Predicted parser state.
  phase_t     phase = PH_WAIT;
  int         held_len = 0;
  logic [7:0] held_bytes [MAX_MESSAGE_BYTES];
  logic       dropped = 1'b0;

  int         errors = 0;
  int         parsed = 0;

  // Decodes a status byte and the phase it opens; returns 0 for non-status bytes.
  function automatic logic status_phase(input logic [7:0] b, output phase_t next_phase);
    status_phase = 1'b1;
    next_phase = PH_WAIT;
    case (b[7:4])
      HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CTRL, HI_PITCH: next_phase = PH_FIRST;
      HI_PROG, HI_CHAN_AT: next_phase = PH_SINGLE;
      default: begin
        case (b)
          ST_SYSEX: next_phase = PH_SYSEX;
          ST_MTC, ST_SONG_SEL: next_phase = PH_SINGLE;
          ST_SONG_POS: next_phase = PH_FIRST;
          default: status_phase = 1'b0;
        endcase
      end
    endcase
  endfunction

  task automatic expect_beat(input logic [7:0] b, input logic is_last, input logic is_trunc);
    run_queue.push_back({b, is_last, is_trunc});
  endtask

  task automatic flag_error(input string what);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  // Advances the predicted parser by one accepted byte and queues any message
  // that the byte completes.
  task automatic parse_byte(input logic [7:0] b);
    phase_t next_phase;
    if (status_phase(b, next_phase)) begin
      // A status byte always abandons whatever message is in progress.
      held_bytes[0] = b;
      held_len = 1;
      dropped = 1'b0;
      phase = next_phase;
      parsed++;
    end else begin
      if (phase != PH_WAIT) begin
        parsed++;
      end
      case (phase)
        PH_FIRST: begin
          held_bytes[1] = b;
          phase = PH_SECOND;
        end
        PH_SECOND: begin
          held_bytes[2] = b;
          phase = PH_FIRST;
          expect_beat(held_bytes[0], 1'b0, 1'b0);
          expect_beat(held_bytes[1], 1'b0, 1'b0);
          expect_beat(b, 1'b1, 1'b0);
        end
        PH_SINGLE: begin
          held_bytes[1] = b;
          expect_beat(held_bytes[0], 1'b0, 1'b0);
          expect_beat(b, 1'b1, 1'b0);
        end
        PH_SYSEX: begin
          if (b == ST_EOX) begin
            if (held_len < MAX_MESSAGE_BYTES) begin
              held_bytes[held_len] = b;
              held_len++;
            end
            for (int i = 0; i < held_len; i++) begin
              expect_beat(held_bytes[i], i == held_len - 1, dropped);
            end
            dropped = 1'b0;
            phase = PH_WAIT;
          end else if (held_len < MAX_MESSAGE_BYTES - 1) begin
            held_bytes[held_len] = b;
            held_len++;
          end else begin
            // The last slot stays free for the closing F7, so this byte is lost.
            dropped = 1'b1;
          end
        end
        default: begin
          // Data bytes while waiting for status are ignored.
        end
      endcase
    end
  endtask

  // Result transfers are checked before the same edge's input transfer is
  // parsed, since a result can only come from an earlier byte.
  always @(posedge clk) begin : monitor
    msg_beat_t want;
    if (!rst_n) begin
      run_queue.delete();
      phase = PH_WAIT;
      held_len = 0;
      dropped = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (run_queue.size() == 0) begin
          flag_error($sformatf("unexpected result byte %02h last %0b truncated %0b",
                               out_msg_byte, out_last, out_truncated));
        end else begin
          want = run_queue.pop_front();
          if (out_msg_byte !== want.msg_byte || out_last !== want.last ||
              out_truncated !== want.truncated) begin
            flag_error($sformatf({"result mismatch: expected byte %02h last %0b ",
                                  "truncated %0b, got byte %02h last %0b truncated %0b"},
                                 want.msg_byte, want.last, want.truncated,
                                 out_msg_byte, out_last, out_truncated));
          end
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_byte);
      end
    end
    error_count <= errors;
    awaited_bytes <= run_queue.size();
    parsed_bytes <= parsed;
  end

endmodule

/* tb/midi_message_assembler_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the MIDI message assembler: drives byte transfers in
// random bursts, stalls the result side and gives the verdict.
// Depends on mma_pkg, midi_message_assembler and midi_message_assembler_checker.

module midi_message_assembler_tb;
  import mma_pkg::*;

  localparam int MAX_MESSAGE_BYTES = 64;
  // Parsed byte count, directed bytes included, at which random stimulus stops.
  localparam int TARGET_BYTES = 230;
  // Longest correct quiet stretch: a sender gap, a receiver stall and a store
  // readout. The limit is many times that.
  localparam int IDLE_LIMIT = 2000;
  // Covers a full 64-byte readout plus receiver stalls.
  localparam int DRAIN_CYCLES = 300;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HOLD} stall_mode_t;
  typedef enum {SEQ_CHANNEL, SEQ_SYSTEM, SEQ_SYSEX, SEQ_NOISE} seq_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_msg_byte;
  logic       out_last;
  logic       out_truncated;

  int error_count;
  int awaited_bytes;
  int parsed_bytes;

  int          burst_left = 0;
  int          idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;
  int          hold_left = 0;
  logic        hold_level = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  midi_message_assembler #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_msg_byte (out_msg_byte),
    .out_last     (out_last),
    .out_truncated(out_truncated)
  );

  midi_message_assembler_checker #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) message_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_msg_byte (out_msg_byte),
    .out_last     (out_last),
    .out_truncated(out_truncated),
    .error_count  (error_count),
    .awaited_bytes(awaited_bytes),
    .parsed_bytes (parsed_bytes)
  );

  // Receiver stall pattern: each mode holds for a random span of cycles.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(32, 256);
    end else begin
      stall_span--;
    end
    if (hold_left == 0) begin
      hold_level = ~hold_level;
      hold_left = $urandom_range(1, 40);
    end else begin
      hold_left--;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 1) == 1);
      STALL_PERIODIC: out_stall <= (stall_span % 4 == 0);
      default:        out_stall <= hold_level;
    endcase
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("midi_message_assembler_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one byte and waits for its transfer; a finished burst is followed
  // by a random gap with valid low.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 16);
      gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Data byte: mostly 7-bit data, sometimes a pass-through byte other than F7.
  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) begin
      b = 8'($urandom_range(8'hF4, 8'hFE));
      if (b >= ST_EOX) begin
        b = b + 8'd1;
      end
    end else begin
      b = 8'($urandom_range(0, 127));
    end
    return b;
  endfunction

  // Sends one message sequence; a broken one stops short of its end.
  task automatic send_sequence(input seq_kind_t kind, input int sysex_len,
                               input logic broken);
    logic [7:0] status;
    int per_msg;
    int runs;
    case (kind)
      SEQ_SYSEX: begin
        send_byte(ST_SYSEX);
        repeat (sysex_len) send_byte(data_byte());
        if (!broken) begin
          send_byte(ST_EOX);
        end
      end
      SEQ_NOISE: begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        if (kind == SEQ_CHANNEL) begin
          status = {4'($urandom_range(HI_NOTE_OFF, HI_PITCH)), 4'($urandom_range(0, 15))};
          per_msg = (status[7:4] == HI_PROG || status[7:4] == HI_CHAN_AT) ? 1 : 2;
          runs = $urandom_range(1, 4);
        end else begin
          case ($urandom_range(0, 2))
            0:       status = ST_MTC;
            1:       status = ST_SONG_POS;
            default: status = ST_SONG_SEL;
          endcase
          per_msg = (status == ST_SONG_POS) ? 2 : 1;
          runs = $urandom_range(1, 2);
        end
        send_byte(status);
        if (broken) begin
          repeat ((runs - 1) * per_msg + $urandom_range(0, per_msg - 1)) send_byte(data_byte());
        end else begin
          repeat (runs * per_msg) send_byte(data_byte());
        end
      end
    endcase
  endtask

  initial begin : stimulus
    logic [7:0] directed [$];
    int stop_at;
    int pick;
    int sysex_len;
    directed = '{
      8'h00, 8'hFF, ST_EOX,                           // ignored while waiting
      {HI_NOTE_ON, 4'h0}, 8'h3C, 8'h7F,               // note on
      8'h00, 8'h7F,                                   // running status
      ST_EOX, 8'hF8,                                  // F7 and F8 taken as data
      {HI_PROG, 4'h5}, 8'h7F, 8'h00,                  // program change, running status
      ST_MTC, 8'h12, ST_SONG_SEL, 8'h05,
      ST_SONG_POS, 8'h01, 8'h7F,
      ST_SYSEX, ST_EOX, 8'h11,                        // empty sysex, then no running status
      ST_SYSEX, 8'hFF, 8'h01, {HI_CHAN_AT, 4'hF}, 8'h7F,  // sysex abandoned by status
      {HI_POLY_AT, 4'h1}, 8'h07, {HI_NOTE_OFF, 4'hE},     // partial message abandoned
      8'h40, 8'h00, {HI_CTRL, 4'h3}, 8'h7F, 8'h7F,
      {HI_PITCH, 4'h9}, 8'h00, 8'h40
    };

    // Hold reset, then release it.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_byte(directed[i]);
    end
    stop_at = TARGET_BYTES;

    // Sysex at the store boundary: one that fills it exactly, one that overflows.
    send_sequence(SEQ_SYSEX, MAX_MESSAGE_BYTES - 2, 1'b0);
    send_sequence(SEQ_SYSEX, MAX_MESSAGE_BYTES + 3, 1'b0);

    // Mostly well-formed sequences with random content, plus noise and
    // sequences cut short by the next status byte.
    while (parsed_bytes < stop_at) begin
      pick = $urandom_range(0, 19);
      sysex_len = ($urandom_range(0, 15) == 0) ?
                  $urandom_range(40, MAX_MESSAGE_BYTES + 6) : $urandom_range(0, 8);
      if (pick < 9) begin
        send_sequence(SEQ_CHANNEL, 0, 1'b0);
      end else if (pick < 11) begin
        send_sequence(SEQ_SYSTEM, 0, 1'b0);
      end else if (pick < 14) begin
        send_sequence(SEQ_SYSEX, sysex_len, 1'b0);
      end else if (pick < 17) begin
        send_sequence(SEQ_NOISE, 0, 1'b0);
      end else begin
        send_sequence(seq_kind_t'($urandom_range(0, 2)), sysex_len, 1'b1);
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected byte, then let the block settle.
    @(posedge clk);
    while (awaited_bytes != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && awaited_bytes == 0) begin
      $display("midi_message_assembler_tb: PASS");
    end else begin
      $display("midi_message_assembler_tb: FAIL");
    end
    $finish;
  end

endmodule

/* midi_message_assembler.f */
rtl/mma_pkg.sv
rtl/mma_ram.sv
rtl/midi_message_assembler.sv
tb/midi_message_assembler_checker.sv
tb/midi_message_assembler_tb.sv
